/* sv/gwm_pkg.sv */
// Shared types and constants for the glob wildcard matcher.
`default_nettype none

package gwm_pkg;

    // Request type codes; code 3 is unused and ignored.
    localparam logic [1:0] REQ_PATTERN = 2'd0;
    localparam logic [1:0] REQ_SUBJECT = 2'd1;
    localparam logic [1:0] REQ_END     = 2'd2;

    localparam logic [7:0] STAR_CODE  = 8'h2A;
    localparam logic [7:0] QUERY_CODE = 8'h3F;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic       pattern_first;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_item;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       load;    // pattern item accepted
        logic       first;   // that pattern item starts a new pattern
        logic       step;    // subject item accepted
        logic       rearm;   // pattern or end-of-name item accepted
        logic [7:0] char_code;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* sv/gwm_cell.sv */
// One pattern position: stored character, in-pattern bit and pre-closure active bit.
`default_nettype none

module gwm_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire gwm_pkg::t_cell_ctl i_ctl,
    input  wire                  i_head,        // tied high on position 0 only
    input  wire                  i_prev_valid,  // left neighbor holds a pattern char
    input  wire                  i_carry,       // star closure from the left
    input  wire                  i_adv,         // char match advancing from the left
    output logic                 o_valid,
    output logic                 o_carry,
    output logic                 o_adv,
    output logic                 o_end          // active and past the pattern end
);
    import gwm_pkg::*;

    logic       r_valid;
    logic       r_base;
    logic [7:0] r_char;
    logic       n_valid;
    logic       n_base;
    logic       w_act;
    logic       w_star;
    logic       w_write;

    assign w_star  = (r_char == STAR_CODE);
    assign w_act   = r_base | i_carry;

    assign o_valid = r_valid;
    assign o_carry = w_act & r_valid & w_star;
    assign o_adv   = w_act & r_valid & ~w_star &
                     ((r_char == QUERY_CODE) || (r_char == i_ctl.char_code));
    assign o_end   = w_act & ~r_valid;

    // A new pattern writes position 0; otherwise the first empty position takes it.
    assign w_write = i_ctl.load & (i_ctl.first ? i_head : (i_prev_valid & ~r_valid));

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.load) begin
            n_valid = i_ctl.first ? i_head : (r_valid | i_prev_valid);
        end
        n_base = r_base;
        if (i_ctl.rearm) begin
            n_base = i_head;
        end else if (i_ctl.step) begin
            // a star keeps its own position; a match moves right
            n_base = o_carry | i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_base  <= i_head;
        end else begin
            r_valid <= n_valid;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_char <= i_ctl.char_code;
        end
    end

endmodule

`default_nettype wire

/* sv/glob_wildcard_matcher_unit.sv */
// Top level of the glob wildcard matcher: cell row, end position and result queue.
`default_nettype none

// Streams name bytes against a glob pattern ('*' any run, '?' any one byte) held in a
// row of MAX_PATTERN cells, one pattern position per cell. Pattern, subject and
// end-of-name items may follow each other back to back while o_in_ready is high. The
// active positions advance through neighbor-to-neighbor links, and star closure ripples
// along the row like a carry chain, so the row length sets the critical path. End-of-
// name items produce one result each through an output register backed by one skid
// entry; input ready drops only while that skid entry is occupied. A pattern longer
// than MAX_PATTERN sets pattern_overflow and every match then reports 0.
module glob_wildcard_matcher_unit #(
    parameter int MAX_PATTERN = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire gwm_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output gwm_pkg::t_out_item  o_out_data
);
    import gwm_pkg::*;

    t_cell_ctl              w_ctl;
    logic                   w_accept;
    logic                   w_produce;
    logic [MAX_PATTERN:0]   w_carry;
    logic [MAX_PATTERN:0]   w_adv;
    logic [MAX_PATTERN:0]   w_pvalid;
    logic [MAX_PATTERN-1:0] w_valid;
    logic [MAX_PATTERN-1:0] w_end;
    logic                   w_hit;
    t_out_item              w_result;

    logic                   r_base_end;
    logic                   n_base_end;
    logic                   r_ovf;
    logic                   n_ovf;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_item              r_out_data;
    t_out_item              n_out_data;
    logic                   r_skid_valid;
    logic                   n_skid_valid;
    t_out_item              r_skid_data;
    t_out_item              n_skid_data;

    assign o_in_ready = ~r_skid_valid;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_produce  = w_accept & (i_in_data.req_type == REQ_END);

    always_comb begin
        w_ctl.load      = w_accept & (i_in_data.req_type == REQ_PATTERN);
        w_ctl.first     = i_in_data.pattern_first;
        w_ctl.step      = w_accept & (i_in_data.req_type == REQ_SUBJECT);
        w_ctl.rearm     = w_accept & ((i_in_data.req_type == REQ_PATTERN) ||
                                      (i_in_data.req_type == REQ_END));
        w_ctl.char_code = i_in_data.char_code;
    end

    assign w_carry[0]  = 1'b0;
    assign w_adv[0]    = 1'b0;
    assign w_pvalid[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        gwm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_head       (k == 0),
            .i_prev_valid (w_pvalid[k]),
            .i_carry      (w_carry[k]),
            .i_adv        (w_adv[k]),
            .o_valid      (w_valid[k]),
            .o_carry      (w_carry[k+1]),
            .o_adv        (w_adv[k+1]),
            .o_end        (w_end[k])
        );
        assign w_pvalid[k+1] = w_valid[k];
    end

    // Active bits past the pattern end exist only at the end position itself.
    assign w_hit = (|w_end) | r_base_end | w_carry[MAX_PATTERN];

    assign w_result.matched          = w_hit & ~r_ovf;
    assign w_result.pattern_overflow = r_ovf;

    always_comb begin
        n_base_end = r_base_end;
        if (w_ctl.rearm) begin
            n_base_end = 1'b0;
        end else if (w_ctl.step) begin
            n_base_end = w_adv[MAX_PATTERN];
        end

        n_ovf = r_ovf;
        if (w_ctl.load) begin
            n_ovf = w_ctl.first ? 1'b0 : (r_ovf | w_pvalid[MAX_PATTERN]);
        end

        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_produce;
                n_out_data  = w_result;
            end
        end else if (w_produce) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_end   <= 1'b0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_base_end   <= n_base_end;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> w_valid[MAX_PATTERN-1])
        else $error("overflow flagged with the pattern row not full");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("pattern cells not a contiguous prefix");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_no_match_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.matched && o_out_data.pattern_overflow))
        else $error("match reported with pattern overflow");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the glob wildcard matcher: random traffic, predictor, scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int MAX_PAT = 32;
    localparam int N_ITEMS = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        t_in_item item;
        bit       hold;   // wait for an empty scoreboard before sending
    } t_queued_req;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    glob_wildcard_matcher_unit #(.MAX_PATTERN(MAX_PAT)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_queued_req req_q[$];
    t_out_item   verdict_q[$];
    int          n_outstanding = 0;
    int          n_err = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_hits = 0;
    int          n_ovf = 0;
    int          cyc = 0;
    bit          hold_next = 1'b0;

    // predictor state
    logic [7:0]       pat_mem [MAX_PAT];
    int               pat_len = 0;
    logic [MAX_PAT:0] live_pos = 'b1;
    bit               pat_ovf = 1'b0;

    task automatic flag_error(string msg);
        n_err++;
        if (n_err <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // empty-run matches: a live star also makes the position after it live
    function automatic logic [MAX_PAT:0] close_stars(logic [MAX_PAT:0] s);
        for (int q = 0; q < pat_len; q++)
            if (s[q] && pat_mem[q] == STAR_CODE)
                s[q + 1] = 1'b1;
        return s;
    endfunction

    function automatic logic [MAX_PAT:0] armed_set();
        logic [MAX_PAT:0] s;
        s = '0;
        s[0] = 1'b1;
        return close_stars(s);
    endfunction

    task automatic predict_glob(t_in_item it);
        logic [MAX_PAT:0] nxt;
        t_out_item        r;
        case (it.req_type)
            REQ_PATTERN: begin
                if (it.pattern_first) begin
                    pat_len = 0;
                    pat_ovf = 1'b0;
                end
                if (pat_len < MAX_PAT) begin
                    pat_mem[pat_len] = it.char_code;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                live_pos = armed_set();
            end
            REQ_SUBJECT: begin
                nxt = '0;
                for (int p = 0; p < pat_len; p++) begin
                    if (live_pos[p]) begin
                        if (pat_mem[p] == STAR_CODE)
                            nxt[p] = 1'b1;
                        else if (pat_mem[p] == QUERY_CODE || pat_mem[p] == it.char_code)
                            nxt[p + 1] = 1'b1;
                    end
                end
                live_pos = close_stars(nxt);
            end
            REQ_END: begin
                r.matched = live_pos[pat_len] && !pat_ovf;
                r.pattern_overflow = pat_ovf;
                verdict_q = {verdict_q, r};
                live_pos = armed_set();
            end
            default: ;
        endcase
    endtask

    // ---------------- driver ----------------
    int in_gap = 0;
    bit in_calm = 1'b0;
    int out_stall = 0;
    bit out_calm = 1'b0;

    function automatic int idle_len(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        logic taken;
        taken = in_valid && o_in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || taken) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (req_q.size() > 0 &&
                         (!req_q[0].hold || (!in_valid && n_outstanding == 0))) begin
                in_data <= req_q[0].item;
                in_valid <= 1'b1;
                req_q.pop_front();
                if ($urandom_range(0, 39) == 0)
                    in_calm = !in_calm;
                in_gap <= idle_len(in_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                out_calm = !out_calm;
            if ($urandom_range(0, 2) == 0)
                out_stall <= idle_len(out_calm);
        end
    end

    // ---------------- monitor / scoreboard ----------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && in_valid && o_in_ready)
            predict_glob(in_data);
        if (i_rst_n && o_out_valid && out_ready) begin
            n_results++;
            if (o_out_data.matched)
                n_hits++;
            if (o_out_data.pattern_overflow)
                n_ovf++;
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("unexpected result matched=%0b overflow=%0b",
                                     o_out_data.matched, o_out_data.pattern_overflow));
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.matched !== want.matched)
                    flag_error($sformatf("matched: expected %0b, got %0b",
                                         want.matched, o_out_data.matched));
                if (o_out_data.pattern_overflow !== want.pattern_overflow)
                    flag_error($sformatf("pattern_overflow: expected %0b, got %0b",
                                         want.pattern_overflow, o_out_data.pattern_overflow));
            end
        end
        n_outstanding <= verdict_q.size();
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc, n_outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    logic [7:0] gen_pat [MAX_PAT];
    int         gen_len = 0;

    task automatic queue_req(logic [1:0] kind, logic [7:0] ch, logic first);
        t_queued_req r;
        r.item.req_type = kind;
        r.item.char_code = ch;
        r.item.pattern_first = first;
        r.hold = hold_next;
        hold_next = 1'b0;
        req_q = {req_q, r};
        if (kind != REQ_UNUSED)
            n_sent++;
    endtask

    task automatic load_text(string s);
        for (int k = 0; k < s.len(); k++)
            queue_req(REQ_PATTERN, s[k], k == 0);
    endtask

    function automatic logic [7:0] rand_pat_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 18)
            return STAR_CODE;
        if (roll < 32)
            return QUERY_CODE;
        if (roll < 85)
            return 8'(8'h61 + $urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_sub_char();
        if ($urandom_range(0, 4) != 0)
            return 8'(8'h61 + $urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0] nm[$];
        logic [7:0] ch;
        int         plen;
        int         n_scen;
        int         cut;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pattern against empty and non-empty names
        queue_req(REQ_END, 8'h00, 1'b0);
        queue_req(REQ_SUBJECT, "a", 1'b0);
        queue_req(REQ_END, 8'hFF, 1'b1);
        // lone star matches the empty name
        load_text("*");
        queue_req(REQ_END, 8'h00, 1'b0);
        // literal, any-one, any-run with extreme bytes
        load_text("a?*");
        queue_req(REQ_SUBJECT, "a", 1'b1);
        queue_req(REQ_SUBJECT, 8'hFF, 1'b0);
        queue_req(REQ_SUBJECT, 8'h00, 1'b0);
        queue_req(REQ_SUBJECT, 8'h80, 1'b0);
        queue_req(REQ_END, 8'h00, 1'b0);
        queue_req(REQ_UNUSED, 8'hFF, 1'b1);
        // pattern byte in the middle of a name rearms and extends the pattern
        queue_req(REQ_SUBJECT, "a", 1'b0);
        queue_req(REQ_PATTERN, "b", 1'b0);
        queue_req(REQ_SUBJECT, "a", 1'b0);
        queue_req(REQ_SUBJECT, "x", 1'b0);
        queue_req(REQ_SUBJECT, "b", 1'b0);
        queue_req(REQ_END, 8'h00, 1'b0);
        // extreme pattern bytes, exact compare
        queue_req(REQ_PATTERN, 8'hFF, 1'b1);
        queue_req(REQ_PATTERN, 8'h00, 1'b0);
        queue_req(REQ_SUBJECT, 8'hFF, 1'b0);
        queue_req(REQ_SUBJECT, 8'h00, 1'b0);
        queue_req(REQ_END, 8'h00, 1'b0);
        gen_pat[0] = 8'hFF;
        gen_pat[1] = 8'h00;
        gen_len = 2;

        // random: mostly names built from the current pattern, plus noise
        n_scen = 0;
        while (n_sent < N_ITEMS) begin
            n_scen++;
            if (n_scen == 60 || $urandom_range(0, 79) == 0)
                hold_next = 1'b1;
            if ($urandom_range(0, 99) < 15) begin
                plen = ($urandom_range(0, 14) == 0) ? $urandom_range(28, 40)
                                                    : $urandom_range(1, 8);
                for (int k = 0; k < plen; k++) begin
                    ch = rand_pat_char();
                    queue_req(REQ_PATTERN, ch, k == 0);
                    if (k < MAX_PAT)
                        gen_pat[k] = ch;
                end
                gen_len = (plen < MAX_PAT) ? plen : MAX_PAT;
            end else if ($urandom_range(0, 29) == 0) begin
                ch = rand_pat_char();
                queue_req(REQ_PATTERN, ch, 1'b0);
                if (gen_len < MAX_PAT) begin
                    gen_pat[gen_len] = ch;
                    gen_len++;
                end
            end
            if ($urandom_range(0, 24) == 0)
                queue_req(REQ_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

            nm.delete();
            if ($urandom_range(0, 3) != 0) begin
                for (int k = 0; k < gen_len; k++) begin
                    if (gen_pat[k] == STAR_CODE) begin
                        repeat ($urandom_range(0, 3)) nm = {nm, rand_sub_char()};
                    end else if (gen_pat[k] == QUERY_CODE) begin
                        nm = {nm, 8'($urandom_range(0, 255))};
                    end else if ($urandom_range(0, 15) == 0) begin
                        nm = {nm, rand_sub_char()};
                    end else if ($urandom_range(0, 40) != 0) begin
                        nm = {nm, gen_pat[k]};
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    nm = {nm, rand_sub_char()};
            end else begin
                repeat ($urandom_range(0, 10)) nm = {nm, rand_sub_char()};
            end

            cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, nm.size()) : -1;
            for (int k = 0; k < nm.size(); k++) begin
                if (k == cut) begin
                    ch = rand_pat_char();
                    queue_req(REQ_PATTERN, ch, 1'b0);
                    if (gen_len < MAX_PAT) begin
                        gen_pat[gen_len] = ch;
                        gen_len++;
                    end
                end
                queue_req(REQ_SUBJECT, nm[k], 1'($urandom_range(0, 1)));
            end
            queue_req(REQ_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end

        while (req_q.size() != 0 || in_valid || n_outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (verdict_q.size() != 0) begin
            void'(verdict_q.pop_front());
            flag_error("expected result never arrived");
        end

        $display("%0d items in %0d name scenarios, %0d results checked", n_sent, n_scen,
                 n_results);
        $display("%0d full matches, %0d overflow reports, %0d errors", n_hits, n_ovf, n_err);
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
